// File: hw/rtl/qafs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qafs_pkg
// Types, constants and codes shared by the quote-aware field splitter.
// ----------------------------------------------------------------------------
package qafs_pkg;

    localparam int MAX_FIELD = 64;
    localparam int LEN_W     = $clog2(MAX_FIELD + 1);
    localparam int ADDR_W    = $clog2(MAX_FIELD);

    localparam logic [7:0] QUOTE_CHAR    = 8'h22;
    localparam logic [7:0] SEP_RESET     = 8'd44;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_QUOTE = 2'd1;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] out_kind;
        logic       field_last;
        logic       string_last;
        logic       field_overflow;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // input item taken this cycle
        logic read;     // capture buffer byte at the read pointer
        logic advance;  // field byte delivered, step the read pointer
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic go_read;  // accepted item ends a field that has bytes to send
        logic go_mark;  // accepted item gives a single empty or end marker
        logic at_end;   // read pointer is on the final byte of the field
    } t_status;

endpackage
`default_nettype wire

// File: hw/rtl/qafs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qafs_dp
// Datapath: configuration registers, field buffer, quote tracking and the
// output payload register.
// ----------------------------------------------------------------------------
module qafs_dp
    import qafs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,
    input  wire t_in_item             i_in,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    output t_out_item                 o_out
);

    logic [7:0]       r_sep;
    logic             r_keep;
    logic [LEN_W-1:0] r_len;
    logic             r_inq;
    logic             r_ovf;
    logic [7:0]       r_first;
    logic [7:0]       r_lastb;
    logic [7:0]       r_mem [MAX_FIELD];
    logic [7:0]       r_rd_data;
    logic [LEN_W-1:0] r_ptr;
    logic [LEN_W-1:0] r_end;
    logic             r_ovf_out;
    logic             r_slast;
    t_kind            r_kind;

    logic             is_quote;
    logic             is_sep;
    logic             full;
    logic             push_ok;
    logic [LEN_W-1:0] flen;
    logic [7:0]       ffirst;
    logic [7:0]       flast;
    logic             ovf_n;
    logic             do_flush;
    logic             strip;
    logic [LEN_W-1:0] fend;
    logic             empty;

    always_comb begin
        is_quote = (i_in.in_char == QUOTE_CHAR);
        is_sep   = !is_quote && (i_in.in_char == r_sep) && !r_inq;
        full     = (r_len == LEN_W'(MAX_FIELD));
        push_ok  = !is_sep && !full;
        flen     = r_len + LEN_W'(push_ok);
        ffirst   = (push_ok && (r_len == '0)) ? i_in.in_char : r_first;
        flast    = push_ok ? i_in.in_char : r_lastb;
        ovf_n    = r_ovf || (!is_sep && full);
        // A separator flushes what is held; any other byte flushes only at the end.
        do_flush = is_sep ? (r_len != '0) : i_in.in_last;
        strip    = !r_keep && (flen >= LEN_W'(2)) &&
                   (ffirst == QUOTE_CHAR) && (flast == QUOTE_CHAR);
        fend     = flen - LEN_W'(strip);
        empty    = strip && (flen == LEN_W'(2));
    end

    assign o_status.go_read = do_flush && !empty;
    assign o_status.go_mark = (do_flush && empty) || (i_in.in_last && !do_flush);
    assign o_status.at_end  = ((r_ptr + LEN_W'(1)) == r_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep  <= SEP_RESET;
            r_keep <= 1'b0;
            r_len  <= '0;
            r_inq  <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SEPARATOR:  r_sep  <= i_cfg_data;
                    CFG_KEEP_QUOTE: r_keep <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                if (is_sep || i_in.in_last) begin
                    r_len <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_len <= flen;
                    r_ovf <= ovf_n;
                end
                if (i_in.in_last) begin
                    r_inq <= 1'b0;
                end else if (is_quote) begin
                    r_inq <= !r_inq;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (push_ok) begin
                r_mem[r_len[ADDR_W-1:0]] <= i_in.in_char;
                r_lastb <= i_in.in_char;
                if (r_len == '0) begin
                    r_first <= i_in.in_char;
                end
            end
            r_ptr     <= LEN_W'(strip);
            r_end     <= fend;
            r_ovf_out <= do_flush && ovf_n;
            r_slast   <= i_in.in_last;
            if (do_flush && !empty) begin
                r_kind <= KIND_BYTE;
            end else if (do_flush) begin
                r_kind <= KIND_EMPTY;
            end else begin
                r_kind <= KIND_END;
            end
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[r_ptr[ADDR_W-1:0]];
        end
        if (i_cmd.advance) begin
            r_ptr <= r_ptr + LEN_W'(1);
        end
    end

    logic flast_out;
    assign flast_out = (r_kind != KIND_BYTE) || o_status.at_end;

    always_comb begin
        o_out.out_char       = (r_kind == KIND_BYTE) ? r_rd_data : 8'd0;
        o_out.out_kind       = r_kind;
        o_out.field_last     = flast_out;
        o_out.string_last    = r_slast && flast_out;
        o_out.field_overflow = (r_kind == KIND_END) ? 1'b0 : r_ovf_out;
    end

endmodule
`default_nettype wire

// File: hw/rtl/qafs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qafs_ctrl
// Controller: takes input items while idle, then walks the buffered field
// one byte at a time or sends a single marker result.
// ----------------------------------------------------------------------------
module qafs_ctrl
    import qafs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_BYTE = 4'b0100,
        S_MARK = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_BYTE) || (r_state == S_MARK);

    always_comb begin
        o_cmd.accept  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.read    = (r_state == S_READ);
        o_cmd.advance = (r_state == S_BYTE) && i_out_ready && !i_status.at_end;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_status.go_read) begin
                    n_state = S_READ;
                end else if (i_in_valid && i_status.go_mark) begin
                    n_state = S_MARK;
                end
            end
            S_READ: n_state = S_BYTE;
            S_BYTE: begin
                if (i_out_ready) begin
                    n_state = i_status.at_end ? S_IDLE : S_READ;
                end
            end
            S_MARK: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/quote_aware_field_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quote_aware_field_splitter
// Splits a byte stream into fields at a separator outside double quotes and
// sends each field byte by byte, optionally without its outer quote pair.
//
//   Channel | Direction | Handshake                   | Payload
//   --------+-----------+-----------------------------+--------------------------
//   in      | input     | i_in_valid / o_in_ready     | i_in  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready   | o_out (t_out_item)
//   cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// An item that ends no field is taken and leaves the block idle. For an item
// that ends a field, each sent byte is read from the single-port field buffer
// in a read state, then offered in a byte state; a marker has its own state.
// Reset is synchronous; the buffer is not cleared and needs no sweep.
// A stalled output holds the block; no item is taken until all results of
// the previous one are delivered. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module quote_aware_field_splitter
    import qafs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    qafs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    qafs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// File: hw/rtl/qafs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qafs_checker
// Port-level checks for the field splitter, bound to the top level.
// ----------------------------------------------------------------------------
module qafs_checker
    import qafs_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out
);

    // The block works on one item at a time, so it never offers a result
    // while it is ready for input.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("result offered while input is ready");

    a_slast_ends_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.string_last) |-> o_out.field_last)
        else $error("string end without field end");

    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.out_kind == KIND_END) |->
        (o_out.field_last && o_out.string_last && o_out.out_char == 8'd0 &&
         !o_out.field_overflow))
        else $error("malformed end-of-string marker");

    // After the final result of a string the block is idle again.
    a_idle_after_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out.string_last) |=> o_in_ready)
        else $error("not ready after end of string");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

endmodule

bind quote_aware_field_splitter qafs_checker u_qafs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire
